// ----- rtl/ggxnd_pkg.sv -----
// Shared types and constants for the GGX normal density pipeline.
package ggxnd_pkg;

  // Fixed widths of the input fields and of the early products.
  localparam int IN_W      = 16;
  localparam int C_W       = 16;
  localparam int C2_W      = 31;
  localparam int A2_W      = 32;
  localparam int A2C_W     = 48;
  localparam int Q_W       = 32;
  localparam int MUL_CHUNK = 32;

  // 1/pi as an unsigned Q0.32 fraction; it fits in 31 bits.
  localparam int                  INV_PI_W   = 31;
  localparam logic [INV_PI_W-1:0] INV_PI_Q32 = 31'd1367130551;

  // One input beat.
  typedef struct packed {
    logic signed [IN_W-1:0] normal_z;
    logic        [IN_W-1:0] roughness;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [Q_W-1:0] density;
    logic           saturated;
  } result_t;

  // Control tag that travels with an item through the divider stages.
  typedef struct packed {
    logic valid;
    logic zero;
    logic ovf;
  } tag_t;

endpackage

// ----- rtl/ggxnd_mul.sv -----
// Two-stage multiplier built from registered 32x32 partial products.
module ggxnd_mul
  import ggxnd_pkg::*;
#(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod
);

  localparam int NA    = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB    = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int PA_W  = NA * MUL_CHUNK;
  localparam int PB_W  = NB * MUL_CHUNK;
  localparam int SUM_W = PA_W + PB_W;
  localparam int PP_W  = 2 * MUL_CHUNK;

  logic [PA_W-1:0]  a_pad;
  logic [PB_W-1:0]  b_pad;
  logic [PP_W-1:0]  pp [NA*NB];
  logic [SUM_W-1:0] sum;

  assign a_pad = PA_W'(a);
  assign b_pad = PB_W'(b);

  // First stage: one registered product for each pair of 32-bit chunks.
  for (genvar gi = 0; gi < NA; gi++) begin : g_row
    for (genvar gj = 0; gj < NB; gj++) begin : g_col
      always_ff @(posedge clk) begin
        pp[gi*NB+gj] <= PP_W'(a_pad[gi*MUL_CHUNK +: MUL_CHUNK])
                      * PP_W'(b_pad[gj*MUL_CHUNK +: MUL_CHUNK]);
      end
    end
  end

  // Second stage: the partial products are aligned and summed.
  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SUM_W'(pp[i*NB+j]) << (MUL_CHUNK * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= sum[A_W+B_W-1:0];
  end

endmodule

// ----- rtl/ggxnd_div_stage.sv -----
// One restoring division stage that settles a single quotient bit.
module ggxnd_div_stage
  import ggxnd_pkg::*;
#(
  parameter int R_W   = 100,
  parameter int D_W   = 68,
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [R_W-1:0] rem_in,
  input  logic [D_W-1:0] div_in,
  input  logic [Q_W-1:0] quo_in,
  input  tag_t           tag_in,
  output logic [R_W-1:0] rem_out,
  output logic [D_W-1:0] div_out,
  output logic [Q_W-1:0] quo_out,
  output tag_t           tag_out
);

  logic [R_W-1:0] div_sh;
  logic           fits;

  // Trial subtraction of the divisor at this stage's bit weight.
  assign div_sh = R_W'(div_in) << SHIFT;
  assign fits   = (rem_in >= div_sh);

  always_ff @(posedge clk) begin
    rem_out <= fits ? (rem_in - div_sh) : rem_in;
    div_out <= div_in;
    quo_out <= {quo_in[Q_W-2:0], fits};
  end

  // The tag carries the valid bit, so it is cleared on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

endmodule

// ----- rtl/ggx_normal_density_core.sv -----
// GGX normal density times |cos|: one beat per cycle.
// An accepted beat passes through these stages in order: nine front stages hold
// the squares, the correction product and the numerator and denominator products, one
// stage checks for overflow, 32 stages each settle one quotient bit, and one output
// register drives the result ports.
// Throughput is one beat in every cycle; busy is always low and the receiver cannot stall.
// Synchronous reset clears every valid bit, so beats in flight at reset are dropped.
module ggx_normal_density_core
  import ggxnd_pkg::*;
#(
  parameter int FRAC_BITS = 15
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    strobe,
  output result_t result
);

  localparam int P           = 2 * FRAC_BITS;
  localparam int ONE_W       = P + 1;
  localparam int DIFF_W      = (ONE_W > A2_W) ? ONE_W : A2_W;
  localparam int CORRP_W     = DIFF_W + C2_W;
  localparam int CORR_W      = CORRP_W - P;
  localparam int WM_W        = ((ONE_W > CORR_W) ? ONE_W : CORR_W) + 1;
  localparam int DEN_W       = 2 * WM_W;
  localparam int NUMP_W      = A2C_W + INV_PI_W;
  localparam int NUM_W       = NUMP_W + FRAC_BITS + 16;
  localparam int NP_W        = NUM_W - Q_W;
  localparam int R_W         = DEN_W + Q_W;
  localparam int CMP_W       = (NP_W > R_W) ? NP_W : R_W;
  localparam int FRONT_DEPTH = 9;

  logic                   accept;
  logic [FRONT_DEPTH-1:0] vld;
  logic [IN_W-1:0]        z_bits;
  logic [C_W-1:0]         c_abs;

  logic [C_W-1:0]         c1;
  logic [IN_W-1:0]        a1;
  logic [C_W-1:0]         c2s;
  logic [C_W-1:0]         c3;
  logic [2*C_W-1:0]       cc3;
  logic [A2_W-1:0]        aa3;
  logic [C2_W-1:0]        c2_3;
  logic [DIFF_W-1:0]      a2_ext;
  logic [DIFF_W-1:0]      one_d;
  logic                   ge3;
  logic [DIFF_W-1:0]      diff3;

  logic [C2_W-1:0]        c2_4;
  logic [DIFF_W-1:0]      diff4;
  logic                   ge4;
  logic                   ge5;
  logic                   ge6;
  logic                   zc4;
  logic                   zc5;
  logic                   zc6;
  logic [A2C_W-1:0]       a2c5;
  logic [CORRP_W-1:0]     prod6;

  logic [CORR_W-1:0]      corr6;
  logic [WM_W-1:0]        one_w;
  logic [WM_W-1:0]        corr_w;
  logic [WM_W-1:0]        wm_next;
  logic [WM_W-1:0]        wm7;
  logic                   zero7;
  logic                   zero8;
  logic                   zero9;
  logic [NUMP_W-1:0]      nump7;
  logic [NUMP_W-1:0]      nump8;
  logic [NUMP_W-1:0]      nump9;
  logic [DEN_W-1:0]       den9;

  logic [NUM_W-1:0]       num9;
  logic [NP_W-1:0]        np9;
  logic                   ovf9;

  logic [R_W-1:0]         rem_s [Q_W+1];
  logic [DEN_W-1:0]       div_s [Q_W+1];
  logic [Q_W-1:0]         quo_s [Q_W+1];
  tag_t                   tag_s [Q_W+1];

  // The pipeline never stalls, so an item is taken whenever start is high.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_DEPTH-2:0], accept};
    end
  end

  // Stage 1: cosine magnitude and roughness.
  assign z_bits = item.normal_z;
  assign c_abs  = z_bits[IN_W-1] ? C_W'(~z_bits + IN_W'(1)) : C_W'(z_bits);

  always_ff @(posedge clk) begin
    c1 <= c_abs;
    a1 <= item.roughness;
  end

  // Stages 2 and 3: the two squares.
  ggxnd_mul #(.A_W(C_W), .B_W(C_W)) u_mul_cc (
    .clk  (clk),
    .a    (c1),
    .b    (c1),
    .prod (cc3)
  );

  ggxnd_mul #(.A_W(IN_W), .B_W(IN_W)) u_mul_aa (
    .clk  (clk),
    .a    (a1),
    .b    (a1),
    .prod (aa3)
  );

  always_ff @(posedge clk) begin
    c2s <= c1;
    c3  <= c2s;
  end

  // Stage 4: distance of alpha squared from one.
  assign c2_3   = cc3[C2_W-1:0];
  assign a2_ext = DIFF_W'(aa3);
  assign one_d  = DIFF_W'(1) << P;
  assign ge3    = (a2_ext >= one_d);
  assign diff3  = ge3 ? (a2_ext - one_d) : (one_d - a2_ext);

  always_ff @(posedge clk) begin
    c2_4  <= c2_3;
    diff4 <= diff3;
    ge4   <= ge3;
    zc4   <= (c2_3 == '0);
  end

  // Stages 4 and 5: alpha squared times the cosine.
  ggxnd_mul #(.A_W(A2_W), .B_W(C_W)) u_mul_a2c (
    .clk  (clk),
    .a    (aa3),
    .b    (c3),
    .prod (a2c5)
  );

  // Stages 5 and 6: correction term of the denominator.
  ggxnd_mul #(.A_W(DIFF_W), .B_W(C2_W)) u_mul_corr (
    .clk  (clk),
    .a    (diff4),
    .b    (c2_4),
    .prod (prod6)
  );

  always_ff @(posedge clk) begin
    ge5 <= ge4;
    ge6 <= ge5;
    zc5 <= zc4;
    zc6 <= zc5;
  end

  // Stages 6 and 7: numerator scaled by one over pi.
  ggxnd_mul #(.A_W(A2C_W), .B_W(INV_PI_W)) u_mul_num (
    .clk  (clk),
    .a    (a2c5),
    .b    (INV_PI_Q32),
    .prod (nump7)
  );

  // Stage 7: magnitude of the denominator base.
  assign corr6  = prod6[CORRP_W-1:P];
  assign one_w  = WM_W'(1) << P;
  assign corr_w = WM_W'(corr6);

  always_comb begin
    if (ge6) begin
      wm_next = one_w + corr_w;
    end else if (corr_w <= one_w) begin
      wm_next = one_w - corr_w;
    end else begin
      wm_next = corr_w - one_w;
    end
  end

  always_ff @(posedge clk) begin
    wm7   <= wm_next;
    zero7 <= zc6 | (wm_next == '0);
  end

  // Stages 8 and 9: squared denominator, with the numerator kept alongside.
  ggxnd_mul #(.A_W(WM_W), .B_W(WM_W)) u_mul_den (
    .clk  (clk),
    .a    (wm7),
    .b    (wm7),
    .prod (den9)
  );

  always_ff @(posedge clk) begin
    nump8 <= nump7;
    nump9 <= nump8;
    zero8 <= zero7;
    zero9 <= zero8;
  end

  // Stage 10: drop the 32 fraction bits below the output and check for overflow.
  assign num9 = NUM_W'(nump9) << (FRAC_BITS + 16);
  assign np9  = num9[NUM_W-1:Q_W];
  assign ovf9 = (CMP_W'(np9) >= (CMP_W'(den9) << Q_W));

  always_ff @(posedge clk) begin
    rem_s[0] <= R_W'(np9);
    div_s[0] <= den9;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s[0] <= '0;
    end else begin
      tag_s[0] <= '{valid: vld[FRONT_DEPTH-1], zero: zero9, ovf: ovf9};
    end
  end

  assign quo_s[0] = '0;

  // Stages 11 to 42: one quotient bit per stage, most significant first.
  for (genvar gk = 0; gk < Q_W; gk++) begin : g_div
    ggxnd_div_stage #(
      .R_W   (R_W),
      .D_W   (DEN_W),
      .SHIFT (Q_W - 1 - gk)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .rem_in  (rem_s[gk]),
      .div_in  (div_s[gk]),
      .quo_in  (quo_s[gk]),
      .tag_in  (tag_s[gk]),
      .rem_out (rem_s[gk+1]),
      .div_out (div_s[gk+1]),
      .quo_out (quo_s[gk+1]),
      .tag_out (tag_s[gk+1])
    );
  end

  // Output register: zero cases first, then saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= tag_s[Q_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_s[Q_W].zero) begin
      result.density   <= '0;
      result.saturated <= 1'b0;
    end else if (tag_s[Q_W].ovf) begin
      result.density   <= '1;
      result.saturated <= 1'b1;
    end else begin
      result.density   <= quo_s[Q_W];
      result.saturated <= 1'b0;
    end
  end

  // Every accepted beat is followed by its result beat on strobe.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##43 strobe)
    else $error("result beat missing 43 cycles after an accepted beat");

  // No result beat appears without a matching accepted beat.
  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept, 43))
    else $error("result beat without a matching input beat");

  // An overflow found before the divider leads to a saturated result.
  a_ovf_to_sat : assert property (@(posedge clk) disable iff (rst)
    tag_s[0].valid && tag_s[0].ovf && !tag_s[0].zero
      |-> ##33 (strobe && result.saturated && (result.density == '1)))
    else $error("overflow did not saturate the result");

endmodule
